// File: hw/rtl/aba_pkg.sv
package aba_pkg;

  localparam int ID_WIDTH_DEF = 8;
  localparam int HINT_W       = 8;
  localparam int FID_W        = 8;
  localparam int STATUS_W     = 2;
  localparam int THRESH_W     = 7;
  localparam int COUNT_W      = 8;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 7'd1;

  typedef enum logic [0:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } command_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_ZERO_ID   = 2'd2,
    ST_NOT_ALLOC = 2'd3
  } status_t;

  // log2 of the map word width, at least two words in the map
  function automatic int word_bits(input int id_w);
    return (id_w > 5) ? 5 : id_w - 1;
  endfunction

  typedef struct packed {
    logic    load;
    logic    rd_first;
    logic    rd_next;
    logic    scan_adv;
    logic    alloc_commit;
    logic    free_commit;
    logic    pend_set;
    status_t pend_code;
    logic    result_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic below_thresh;
    logic fid_zero;
    logic fid_oob;
    logic hit;
    logic scan_last;
    logic bit_used;
  } dp_stat_t;

endpackage

// File: hw/rtl/aba_map_mem.sv
module aba_map_mem import aba_pkg::*; #(
  parameter int WORD_W = 32,
  parameter int ADDR_W = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WORD_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WORD_W-1:0] wr_data
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid;

  // unwritten words read as the reset map: id 0 marked used
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (valid[rd_addr]) begin
        rd_data <= mem[rd_addr];
      end else if (rd_addr == '0) begin
        rd_data <= WORD_W'(1);
      end else begin
        rd_data <= '0;
      end
    end
  end

endmodule

// File: hw/rtl/aba_datapath.sv
module aba_datapath import aba_pkg::*; #(
  parameter int ID_WIDTH = ID_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                command,
  input  logic [HINT_W-1:0]   start_hint,
  input  logic [FID_W-1:0]    free_id,
  input  logic                cfg_we,
  input  logic [THRESH_W-1:0] cfg_wdata,
  input  dp_cmd_t             cmd,
  output dp_stat_t            stat,
  output logic [STATUS_W-1:0] status,
  output logic [7:0]          granted_id,
  output logic [COUNT_W-1:0]  free_count
);

  localparam int WORD_BITS = word_bits(ID_WIDTH);
  localparam int WORD_W    = 1 << WORD_BITS;
  localparam int WADDR_W   = ID_WIDTH - WORD_BITS;
  localparam int NUM_WORDS = 1 << WADDR_W;
  localparam int NUM_IDS   = 1 << ID_WIDTH;
  localparam int STEP_W    = WADDR_W + 1;
  localparam int EXT_W     = (ID_WIDTH > 8) ? ID_WIDTH : 8;
  localparam int CMP_W     = (ID_WIDTH > THRESH_W) ? ID_WIDTH : THRESH_W;

  logic                 cmd_free;
  logic [WORD_BITS-1:0] pos_bit;
  logic [WADDR_W-1:0]   scan_word;
  logic [STEP_W-1:0]    step;
  logic [ID_WIDTH-1:0]  fid;
  logic                 fid_oob;
  logic [ID_WIDTH-1:0]  free_left;
  logic [THRESH_W-1:0]  thresh;
  status_t              pend_status;
  logic [ID_WIDTH-1:0]  pend_id;

  logic [EXT_W-1:0]     hint_ext;
  logic [EXT_W-1:0]     fid_ext;
  logic [EXT_W-1:0]     pend_ext;
  logic [EXT_W-1:0]     count_ext;
  logic [ID_WIDTH-1:0]  start_id;
  logic [WADDR_W-1:0]   rd_addr;
  logic                 rd_en;
  logic [WORD_W-1:0]    rd_word;
  logic [WORD_W-1:0]    low_mask;
  logic [WORD_W-1:0]    masked;
  logic [WORD_BITS-1:0] first_zero;
  logic [WORD_BITS-1:0] fid_bit;
  logic [WADDR_W-1:0]   fid_word;
  logic                 wr_en;
  logic [WADDR_W-1:0]   wr_addr;
  logic [WORD_W-1:0]    wr_data;

  assign hint_ext  = EXT_W'(start_hint);
  assign fid_ext   = EXT_W'(free_id);
  assign start_id  = hint_ext[ID_WIDTH-1:0] + ID_WIDTH'(1);
  assign fid_bit   = fid[WORD_BITS-1:0];
  assign fid_word  = fid[ID_WIDTH-1:WORD_BITS];
  assign pend_ext  = EXT_W'(pend_id);
  assign count_ext = EXT_W'(free_left);

  assign rd_en   = cmd.rd_first | cmd.rd_next;
  assign rd_addr = cmd.rd_first ? (cmd_free ? fid_word : scan_word)
                                : scan_word + WADDR_W'(1);

  // bits below the start offset count as used on the first word only
  assign low_mask = (step == '0) ? ((WORD_W'(1) << pos_bit) - WORD_W'(1)) : '0;
  assign masked   = rd_word | low_mask;

  always_comb begin
    first_zero = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!masked[i]) begin
        first_zero = WORD_BITS'(i);
      end
    end
  end

  assign stat.is_free      = cmd_free;
  assign stat.below_thresh = CMP_W'(free_left) < CMP_W'(thresh);
  assign stat.fid_zero     = (fid == '0) && !fid_oob;
  assign stat.fid_oob      = fid_oob;
  assign stat.hit          = ~&masked;
  assign stat.scan_last    = (step == STEP_W'(NUM_WORDS));
  assign stat.bit_used     = rd_word[fid_bit];

  assign wr_en   = cmd.alloc_commit | cmd.free_commit;
  assign wr_addr = cmd_free ? fid_word : scan_word;
  assign wr_data = cmd_free ? (rd_word & ~(WORD_W'(1) << fid_bit))
                            : (rd_word | (WORD_W'(1) << first_zero));

  aba_map_mem #(
    .WORD_W (WORD_W),
    .ADDR_W (WADDR_W)
  ) u_map (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_word),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      free_left <= ID_WIDTH'(NUM_IDS - 1);
      thresh    <= THRESH_RESET;
    end else begin
      if (cfg_we) begin
        thresh <= cfg_wdata;
      end
      if (cmd.alloc_commit && free_left != '0) begin
        free_left <= free_left - ID_WIDTH'(1);
      end else if (cmd.free_commit) begin
        free_left <= free_left + ID_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_free  <= (command == CMD_FREE);
      pos_bit   <= start_id[WORD_BITS-1:0];
      scan_word <= start_id[ID_WIDTH-1:WORD_BITS];
      step      <= '0;
      fid       <= fid_ext[ID_WIDTH-1:0];
      fid_oob   <= |(fid_ext >> ID_WIDTH);
    end else if (cmd.scan_adv) begin
      scan_word <= scan_word + WADDR_W'(1);
      step      <= step + STEP_W'(1);
    end
    if (cmd.alloc_commit) begin
      pend_status <= ST_OK;
      pend_id     <= {scan_word, first_zero};
    end else if (cmd.free_commit) begin
      pend_status <= ST_OK;
      pend_id     <= '0;
    end else if (cmd.pend_set) begin
      pend_status <= cmd.pend_code;
      pend_id     <= '0;
    end
    if (cmd.result_load) begin
      status     <= pend_status;
      granted_id <= pend_ext[7:0];
      free_count <= count_ext[COUNT_W-1:0];
    end
  end

endmodule

// File: hw/rtl/aba_ctrl.sv
module aba_ctrl import aba_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_FCHK,
    S_RESULT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!stat.is_free) begin
          if (stat.below_thresh) begin
            cmd.pend_set  = 1'b1;
            cmd.pend_code = ST_EXHAUSTED;
            state_next    = S_RESULT;
          end else begin
            cmd.rd_first = 1'b1;
            state_next   = S_SCAN;
          end
        end else if (stat.fid_zero) begin
          cmd.pend_set  = 1'b1;
          cmd.pend_code = ST_ZERO_ID;
          state_next    = S_RESULT;
        end else if (stat.fid_oob) begin
          cmd.pend_set  = 1'b1;
          cmd.pend_code = ST_NOT_ALLOC;
          state_next    = S_RESULT;
        end else begin
          cmd.rd_first = 1'b1;
          state_next   = S_FCHK;
        end
      end
      S_SCAN: begin
        cmd.rd_next = 1'b1;
        if (stat.hit) begin
          cmd.alloc_commit = 1'b1;
          state_next       = S_RESULT;
        end else if (stat.scan_last) begin
          cmd.pend_set  = 1'b1;
          cmd.pend_code = ST_EXHAUSTED;
          state_next    = S_RESULT;
        end else begin
          cmd.scan_adv = 1'b1;
        end
      end
      S_FCHK: begin
        if (stat.bit_used) begin
          cmd.free_commit = 1'b1;
        end else begin
          cmd.pend_set  = 1'b1;
          cmd.pend_code = ST_NOT_ALLOC;
        end
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid || out_ready) begin
          cmd.result_load = 1'b1;
          out_valid_next  = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: hw/rtl/asid_bitmap_allocator.sv
// channel   direction  handshake            payload
// request   in         in_valid/in_ready    command, start_hint, free_id
// result    out        out_valid/out_ready  status, granted_id, free_count
// config    in         cfg_we               cfg_wdata (reserve threshold)
//
// free runs from accept through decide, free check and result; a threshold refusal
// goes from decide to result; allocate scans one map word per cycle, up to one more
// than the map has (9 words at 256 ids), set by the single read port of the map
// reset takes effect at once: per-word valid bits present the reset map
// a finished result waits in the output register while the next request is taken;
// the result after it waits until the output register is free
module asid_bitmap_allocator import aba_pkg::*; #(
  parameter int ID_WIDTH = ID_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                command,
  input  logic [HINT_W-1:0]   start_hint,
  input  logic [FID_W-1:0]    free_id,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [7:0]          granted_id,
  output logic [COUNT_W-1:0]  free_count,
  input  logic                cfg_we,
  input  logic [THRESH_W-1:0] cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  aba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  aba_datapath #(
    .ID_WIDTH (ID_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .command    (command),
    .start_hint (start_hint),
    .free_id    (free_id),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .stat       (stat),
    .status     (status),
    .granted_id (granted_id),
    .free_count (free_count)
  );

endmodule

// File: hw/rtl/aba_checker.sv
module aba_checker import aba_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] status,
  input logic [7:0]          granted_id,
  input logic [COUNT_W-1:0]  free_count
);

  // stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) &&
      $stable(granted_id) && $stable(free_count))
    else $error("result changed while stalled");

  // one request at a time
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // refused or ignored requests grant no id
  a_no_grant: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> granted_id == '0)
    else $error("id granted with error status");

  // reset leaves the block idle and empty
  a_reset_idle: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("not idle after reset");

endmodule

bind asid_bitmap_allocator aba_checker u_aba_checker (.*);
